>>> hdl/assert_macros.svh
// Concurrent assertion helpers; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CHK_IMPLY(lbl, clk, rst, ante, cons, msg)
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> hdl/fft_pkg.sv
package fft_pkg;

   localparam int MAX_POINTS   = 64;
   localparam int MAX_LOG2     = 6;
   localparam int SAMPLE_BITS  = 24;
   localparam int TWIDDLE_BITS = 16;

   localparam logic [0:0] REG_LOG2_POINTS  = 1'd0;
   localparam logic [0:0] REG_INVERSE_MODE = 1'd1;

   typedef struct packed {
      logic signed [23:0] sample_re;
      logic signed [23:0] sample_im;
   } req_type;

   typedef struct packed {
      logic signed [23:0] out_re;
      logic signed [23:0] out_im;
      logic [5:0]         bin_index;
      logic               last_bin;
   } rsp_type;

   function automatic logic [5:0] bit_rev(input logic [5:0] v, input logic [2:0] l);
      logic [5:0] r;
      for (int i = 0; i < 6; i++) r[i] = v[5-i];
      return r >> (3'd6 - l);
   endfunction

   function automatic logic signed [15:0] cos_rom(input logic [4:0] q);
      logic signed [15:0] r;
      case (q)
         5'd0:  r = 16'sd32767;
         5'd1:  r = 16'sd32610;
         5'd2:  r = 16'sd32138;
         5'd3:  r = 16'sd31357;
         5'd4:  r = 16'sd30274;
         5'd5:  r = 16'sd28899;
         5'd6:  r = 16'sd27246;
         5'd7:  r = 16'sd25330;
         5'd8:  r = 16'sd23170;
         5'd9:  r = 16'sd20788;
         5'd10: r = 16'sd18205;
         5'd11: r = 16'sd15447;
         5'd12: r = 16'sd12540;
         5'd13: r = 16'sd9512;
         5'd14: r = 16'sd6393;
         5'd15: r = 16'sd3212;
         default: r = 16'sd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [15:0] tw_cos(input logic [5:0] q);
      logic [5:0] m;
      logic signed [15:0] r;
      if (q <= 6'd16) begin
         r = cos_rom(q[4:0]);
      end else if (q <= 6'd32) begin
         m = 6'd32 - q;
         r = -cos_rom(m[4:0]);
      end else if (q <= 6'd48) begin
         m = q - 6'd32;
         r = -cos_rom(m[4:0]);
      end else begin
         m = 6'd0 - q;
         r = cos_rom(m[4:0]);
      end
      return r;
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
      logic signed [23:0] r;
      if (v > 27'sd8388607) r = 24'sh7fffff;
      else if (v < -27'sd8388608) r = 24'sh800000;
      else r = v[23:0];
      return r;
   endfunction

endpackage

>>> hdl/radix2_fft_forward_inverse.sv
// Radix-2 decimation-in-time FFT over 1 to 64 complex 24-bit samples, forward
// unscaled or inverse divided by N. Samples load one per cycle in natural order
// into a 64-entry store; once N are in, the block stalls input, runs L = log2 N
// stages of N/2 butterflies on one shared butterfly unit (two reads and two
// writes each on the store's one read port and one write port), then emits bins
// in order, one at a time, each held until the result side does not stall.
`include "assert_macros.svh"
module radix2_fft_forward_inverse (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fft_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fft_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [0:0]       csr_addr,
   input  logic [2:0]       csr_wdata
);

   typedef enum logic [9:0] {
      S_LOAD  = 10'b0000000001,
      S_RA    = 10'b0000000010,
      S_RB    = 10'b0000000100,
      S_MUL   = 10'b0000001000,
      S_ADD   = 10'b0000010000,
      S_WA    = 10'b0000100000,
      S_WB    = 10'b0001000000,
      S_ERD   = 10'b0010000000,
      S_ECAP  = 10'b0100000000,
      S_EHOLD = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   logic [2:0] log2_cfg_ff, log2_cfg_in;
   logic       inv_cfg_ff, inv_cfg_in;
   logic [2:0] l_ff, l_in;
   logic       inv_ff, inv_in;
   logic [6:0] count_ff, count_in;
   logic [2:0] stage_ff, stage_in;
   logic [4:0] bf_ff, bf_in;
   logic [5:0] bin_ff, bin_in;

   logic [47:0] mem [fft_pkg::MAX_POINTS];
   logic [47:0] rd_q_ff;
   logic [5:0]  rd_addr;
   logic        wr_en;
   logic [5:0]  wr_addr;
   logic [47:0] wr_data;

   logic [47:0] t_ff;
   logic signed [23:0] br_ff, bi_ff;
   logic        e0_ff;
   logic signed [39:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [23:0] sum_re_ff, sum_im_ff, dif_re_ff, dif_im_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   fft_pkg::rsp_type rsp_ff, rsp_in;

   logic       accept;
   logic [2:0] lc;
   logic [6:0] n_cur, n_run;
   logic [5:0] half, lo, j6, a_pos, b_pos, e_cur;
   logic [4:0] bf_last;
   logic signed [15:0] wr_tw, ws_tw, wi_tw;
   logic signed [23:0] b_re, b_im, t_re, t_im;
   logic signed [40:0] s_re, s_im;
   logic signed [25:0] h_re, h_im;
   logic signed [24:0] sc_re, sc_im;
   logic [24:0] sc_rnd;

   always_comb begin
      lc      = (log2_cfg_ff > 3'd6) ? 3'd6 : log2_cfg_ff;
      n_cur   = 7'd1 << lc;
      n_run   = 7'd1 << l_ff;
      half    = 6'd1 << (stage_ff - 3'd1);
      lo      = half - 6'd1;
      j6      = {1'b0, bf_ff};
      a_pos   = ((j6 & ~lo) << 1) | (j6 & lo);
      b_pos   = a_pos | half;
      e_cur   = (j6 & lo) << (3'd6 - stage_ff);
      bf_last = 5'((n_run >> 1) - 7'd1);
      wr_tw   = fft_pkg::tw_cos(e_cur);
      ws_tw   = fft_pkg::tw_cos(e_cur - 6'd16);
      wi_tw   = inv_ff ? ws_tw : -ws_tw;
      b_re    = rd_q_ff[47:24];
      b_im    = rd_q_ff[23:0];
      t_re    = t_ff[47:24];
      t_im    = t_ff[23:0];
      s_re    = 41'(p_rr_ff) - 41'(p_ii_ff) + 41'sd16384;
      s_im    = 41'(p_ri_ff) + 41'(p_ir_ff) + 41'sd16384;
      h_re    = e0_ff ? 26'(br_ff) : s_re[40:15];
      h_im    = e0_ff ? 26'(bi_ff) : s_im[40:15];
      sc_rnd  = (inv_ff && l_ff != 3'd0) ? (25'd1 << (l_ff - 3'd1)) : 25'd0;
      sc_re   = (25'(b_re) + $signed(sc_rnd)) >>> (inv_ff ? l_ff : 3'd0);
      sc_im   = (25'(b_im) + $signed(sc_rnd)) >>> (inv_ff ? l_ff : 3'd0);
   end

   assign req_stall = (state_ff != S_LOAD);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      log2_cfg_in  = log2_cfg_ff;
      inv_cfg_in   = inv_cfg_ff;
      l_in         = l_ff;
      inv_in       = inv_ff;
      count_in     = count_ff;
      stage_in     = stage_ff;
      bf_in        = bf_ff;
      bin_in       = bin_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      rd_addr      = fft_pkg::bit_rev(a_pos, l_ff);
      wr_en        = 1'b0;
      wr_addr      = count_ff[5:0];
      wr_data      = {req_data.sample_re, req_data.sample_im};

      if (csr_we) begin
         unique case (csr_addr)
            fft_pkg::REG_LOG2_POINTS:  log2_cfg_in = csr_wdata;
            fft_pkg::REG_INVERSE_MODE: inv_cfg_in  = csr_wdata[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_LOAD: begin
            if (accept) begin
               wr_en    = (count_ff < 7'(fft_pkg::MAX_POINTS));
               count_in = count_ff + 7'd1;
               if (count_ff + 7'd1 >= n_cur) begin
                  count_in = 7'd0;
                  l_in     = lc;
                  inv_in   = inv_cfg_ff;
                  stage_in = 3'd1;
                  bf_in    = 5'd0;
                  bin_in   = 6'd0;
                  state_in = (lc == 3'd0) ? S_ERD : S_RA;
               end
            end
         end
         S_RA: state_in = S_RB;
         S_RB: begin
            rd_addr  = fft_pkg::bit_rev(b_pos, l_ff);
            state_in = S_MUL;
         end
         S_MUL: state_in = S_ADD;
         S_ADD: state_in = S_WA;
         S_WA: begin
            wr_en    = 1'b1;
            wr_addr  = fft_pkg::bit_rev(a_pos, l_ff);
            wr_data  = {sum_re_ff, sum_im_ff};
            state_in = S_WB;
         end
         S_WB: begin
            wr_en   = 1'b1;
            wr_addr = fft_pkg::bit_rev(b_pos, l_ff);
            wr_data = {dif_re_ff, dif_im_ff};
            if (bf_ff == bf_last) begin
               bf_in = 5'd0;
               if (stage_ff == l_ff) begin
                  state_in = S_ERD;
               end else begin
                  stage_in = stage_ff + 3'd1;
                  state_in = S_RA;
               end
            end else begin
               bf_in    = bf_ff + 5'd1;
               state_in = S_RA;
            end
         end
         S_ERD: begin
            rd_addr  = fft_pkg::bit_rev(bin_ff, l_ff);
            state_in = S_ECAP;
         end
         S_ECAP: begin
            rsp_in.out_re    = sc_re[23:0];
            rsp_in.out_im    = sc_im[23:0];
            rsp_in.bin_index = bin_ff;
            rsp_in.last_bin  = ({1'b0, bin_ff} == n_run - 7'd1);
            rsp_valid_in     = 1'b1;
            state_in         = S_EHOLD;
         end
         S_EHOLD: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (rsp_ff.last_bin) begin
                  state_in = S_LOAD;
               end else begin
                  bin_in   = bin_ff + 6'd1;
                  state_in = S_ERD;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_q_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_RB) t_ff <= rd_q_ff;
      if (state_ff == S_MUL) begin
         br_ff   <= b_re;
         bi_ff   <= b_im;
         e0_ff   <= (e_cur == 6'd0);
         p_rr_ff <= b_re * wr_tw;
         p_ii_ff <= b_im * wi_tw;
         p_ri_ff <= b_re * wi_tw;
         p_ir_ff <= b_im * wr_tw;
      end
      if (state_ff == S_ADD) begin
         sum_re_ff <= fft_pkg::sat24(27'(t_re) + 27'(h_re));
         sum_im_ff <= fft_pkg::sat24(27'(t_im) + 27'(h_im));
         dif_re_ff <= fft_pkg::sat24(27'(t_re) - 27'(h_re));
         dif_im_ff <= fft_pkg::sat24(27'(t_im) - 27'(h_im));
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         log2_cfg_ff  <= 3'd6;
         inv_cfg_ff   <= 1'b0;
         l_ff         <= 3'd6;
         inv_ff       <= 1'b0;
         count_ff     <= 7'd0;
         stage_ff     <= 3'd1;
         bf_ff        <= 5'd0;
         bin_ff       <= 6'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         log2_cfg_ff  <= log2_cfg_in;
         inv_cfg_ff   <= inv_cfg_in;
         l_ff         <= l_in;
         inv_ff       <= inv_in;
         count_ff     <= count_in;
         stage_ff     <= stage_in;
         bf_ff        <= bf_in;
         bin_ff       <= bin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `CHK_IMPLY(a_no_overlap, clock, reset, rsp_valid, req_stall, "result beat during load")
   `CHK_IMPLY(a_last_index, clock, reset, rsp_valid && rsp_data.last_bin, {1'b0, rsp_data.bin_index} == n_run - 7'd1, "last bin index wrong")
   `CHK_NEXT(a_stage_done, clock, reset, state_ff == S_WB && bf_ff == bf_last && stage_ff == l_ff, state_ff == S_ERD, "emit did not follow final stage")
   `CHK_IMPLY(a_count_range, clock, reset, 1'b1, count_ff < n_cur || state_ff != S_LOAD || count_ff != 7'd0, "load count out of range")

endmodule
